// ===== sv/dssd_pkg.sv =====
// Shared types and constants for the DVB subtitle segment deframer.
// No dependencies; compile this file first.
package dssd_pkg;

  // Fixed byte values of the framing.
  localparam logic [7:0] PKT_HDR0 = 8'h20;
  localparam logic [7:0] PKT_HDR1 = 8'h00;
  localparam logic [7:0] SEG_SYNC = 8'h0f;
  localparam logic [7:0] PKT_END  = 8'hff;

  // A segment header is the sync byte and five more bytes.
  localparam int unsigned SEG_HDR_LEN = 6;
  localparam logic [2:0] LEN_HIGH_IDX = 3'(SEG_HDR_LEN - 2);
  localparam logic [2:0] LEN_LOW_IDX  = 3'(SEG_HDR_LEN - 1);

  // Role tag carried with every byte.
  typedef enum logic [2:0] {
    ROLE_OUTSIDE = 3'd0,
    ROLE_HEADER  = 3'd1,
    ROLE_SEGMENT = 3'd2,
    ROLE_END     = 3'd3,
    ROLE_JUNK    = 3'd4
  } role_t;

  // Error tag carried with every byte.
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BAD_HDR = 2'd1,
    ERR_JUNK    = 2'd2
  } err_t;

endpackage

// ===== sv/dssd_in_if.sv =====
// Valid/ready channel that carries raw payload bytes into the deframer.
// Depends on nothing.
interface dssd_in_if;
  logic       valid;
  logic       ready;
  logic       new_packet;
  logic [7:0] data_byte;

  modport source (output valid, output new_packet, output data_byte, input ready);
  modport sink (input valid, input new_packet, input data_byte, output ready);
endinterface

// ===== sv/dssd_out_if.sv =====
// Valid/ready channel that carries tagged bytes out of the deframer.
// Depends on dssd_pkg for the role and error types.
interface dssd_out_if;
  logic            valid;
  logic            ready;
  logic [7:0]      out_byte;
  dssd_pkg::role_t byte_role;
  logic            segment_first;
  logic            segment_last;
  logic            discard_open;
  dssd_pkg::err_t  error_code;

  modport source (
    output valid, output out_byte, output byte_role, output segment_first,
    output segment_last, output discard_open, output error_code, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_role, input segment_first,
    input segment_last, input discard_open, input error_code, output ready
  );
endinterface

// ===== sv/dvb_subtitle_segment_deframer.sv =====
// Top level of the DVB subtitle segment deframer.
// Depends on dssd_pkg, dssd_in_if and dssd_out_if.

// The deframer takes one subtitle payload byte per beat on the payload channel
// and returns exactly one tagged beat per input beat on the framed channel, in
// order. Each packet must open with the header bytes 0x20 0x00; after that the
// stream is cut into segments, each a 0x0f sync byte, five more header bytes
// whose last two hold a big-endian body length, and then that many body bytes.
// At a segment boundary a 0xff byte ends the packet cleanly and any other byte
// is reported as junk. Every byte is passed through with its role, a mark on
// the sync byte, a mark on the byte that completes a segment, a discard flag
// when a new packet cuts an open segment short, and an error code. Each byte
// is classified combinationally by a small state machine and held in one
// result register, so the block sustains one beat per clock cycle and each
// result appears in the cycle after its byte is taken; the only thing that
// stops it is a stall on the framed channel while the result register is full.
module dvb_subtitle_segment_deframer (
  input  logic        clk,
  input  logic        rst,
  dssd_in_if.sink     payload,
  dssd_out_if.source  framed
);

  // Framing state. Values beyond BODY are never entered.
  typedef enum logic [2:0] {
    OUTSIDE  = 3'd0,
    HDR1     = 3'd1,
    SEGSTART = 3'd2,
    SEGHDR   = 3'd3,
    BODY     = 3'd4
  } mode_t;

  mode_t       mode, mode_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] body_remaining, body_remaining_next;

  // Result register and its fill flag.
  logic            res_valid;
  logic [7:0]      res_byte;
  dssd_pkg::role_t res_role, role_next;
  logic            res_first, first_next;
  logic            res_last, last_next;
  logic            res_discard, discard_next;
  dssd_pkg::err_t  res_err, err_next;

  logic        accept;
  logic [15:0] seg_len;
  logic [15:0] body_dec;

  // A new beat is taken whenever the result register is empty or is being
  // emptied in the same cycle.
  assign payload.ready = !res_valid || framed.ready;
  assign accept        = payload.valid && payload.ready;

  assign seg_len  = {length_high, payload.data_byte};
  assign body_dec = body_remaining - 16'd1;

  always_comb begin
    mode_next           = mode;
    header_count_next   = header_count;
    length_high_next    = length_high;
    body_remaining_next = body_remaining;
    role_next           = dssd_pkg::ROLE_OUTSIDE;
    first_next          = 1'b0;
    last_next           = 1'b0;
    discard_next        = 1'b0;
    err_next            = dssd_pkg::ERR_NONE;

    if (payload.new_packet) begin
      // A new packet always restarts framing; a segment that was still being
      // collected is lost and flagged. A pending second header byte is not a
      // segment, so it raises no discard.
      discard_next        = (mode == SEGHDR) || (mode == BODY);
      header_count_next   = 3'd0;
      body_remaining_next = 16'd0;
      role_next           = dssd_pkg::ROLE_HEADER;
      if (payload.data_byte == dssd_pkg::PKT_HDR0) begin
        mode_next = HDR1;
      end else begin
        err_next  = dssd_pkg::ERR_BAD_HDR;
        mode_next = OUTSIDE;
      end
    end else begin
      unique case (mode)
        HDR1: begin
          role_next = dssd_pkg::ROLE_HEADER;
          if (payload.data_byte == dssd_pkg::PKT_HDR1) begin
            mode_next = SEGSTART;
          end else begin
            err_next  = dssd_pkg::ERR_BAD_HDR;
            mode_next = OUTSIDE;
          end
        end
        SEGSTART: begin
          if (payload.data_byte == dssd_pkg::SEG_SYNC) begin
            role_next         = dssd_pkg::ROLE_SEGMENT;
            first_next        = 1'b1;
            header_count_next = 3'd1;
            mode_next         = SEGHDR;
          end else if (payload.data_byte == dssd_pkg::PKT_END) begin
            role_next = dssd_pkg::ROLE_END;
            mode_next = OUTSIDE;
          end else begin
            role_next = dssd_pkg::ROLE_JUNK;
            err_next  = dssd_pkg::ERR_JUNK;
            mode_next = OUTSIDE;
          end
        end
        SEGHDR: begin
          role_next = dssd_pkg::ROLE_SEGMENT;
          if (header_count == dssd_pkg::LEN_HIGH_IDX) begin
            length_high_next = payload.data_byte;
          end
          if (header_count >= dssd_pkg::LEN_LOW_IDX) begin
            // Last header byte: the length is complete. An empty segment
            // ends right here.
            header_count_next = 3'd0;
            if (seg_len == 16'd0) begin
              last_next = 1'b1;
              mode_next = SEGSTART;
            end else begin
              body_remaining_next = seg_len;
              mode_next           = BODY;
            end
          end else begin
            header_count_next = header_count + 3'd1;
          end
        end
        BODY: begin
          role_next           = dssd_pkg::ROLE_SEGMENT;
          body_remaining_next = body_dec;
          if (body_dec == 16'd0) begin
            last_next = 1'b1;
            mode_next = SEGSTART;
          end
        end
        default: begin
          // Outside a packet, including after an end marker or junk.
          mode_next = OUTSIDE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= OUTSIDE;
      header_count   <= 3'd0;
      length_high    <= 8'd0;
      body_remaining <= 16'd0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        mode           <= mode_next;
        header_count   <= header_count_next;
        length_high    <= length_high_next;
        body_remaining <= body_remaining_next;
        res_valid      <= 1'b1;
      end else if (framed.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by res_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_byte    <= payload.data_byte;
      res_role    <= role_next;
      res_first   <= first_next;
      res_last    <= last_next;
      res_discard <= discard_next;
      res_err     <= err_next;
    end
  end

  assign framed.valid         = res_valid;
  assign framed.out_byte      = res_byte;
  assign framed.byte_role     = res_role;
  assign framed.segment_first = res_first;
  assign framed.segment_last  = res_last;
  assign framed.discard_open  = res_discard;
  assign framed.error_code    = res_err;

endmodule

// ===== sv/dssd_checker.sv =====
// Port-level checks for the DVB subtitle segment deframer, bound to its top.
// Depends on dssd_pkg and on dvb_subtitle_segment_deframer.
module dssd_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic [7:0]      out_byte,
  input dssd_pkg::role_t byte_role,
  input logic            segment_first,
  input logic            discard_open,
  input dssd_pkg::err_t  error_code
);

  // A stalled beat keeps its byte and its role.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_role))
    else $error("framed beat changed while stalled");

  // A segment opens only on a sync byte tagged as a segment byte.
  a_first_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment_first |->
      out_byte == dssd_pkg::SEG_SYNC && byte_role == dssd_pkg::ROLE_SEGMENT)
    else $error("segment start on a byte that is not a sync byte");

  // Discards are only reported on the first header byte of a packet.
  a_discard_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && discard_open |-> byte_role == dssd_pkg::ROLE_HEADER)
    else $error("discard flagged outside a packet header byte");

  // Error codes agree with the role of the byte.
  a_err_role: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (error_code == dssd_pkg::ERR_NONE) ||
      (error_code == dssd_pkg::ERR_BAD_HDR && byte_role == dssd_pkg::ROLE_HEADER) ||
      (error_code == dssd_pkg::ERR_JUNK && byte_role == dssd_pkg::ROLE_JUNK))
    else $error("error code does not match byte role");

endmodule

bind dvb_subtitle_segment_deframer dssd_checker u_dssd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (framed.valid),
  .out_ready     (framed.ready),
  .out_byte      (framed.out_byte),
  .byte_role     (framed.byte_role),
  .segment_first (framed.segment_first),
  .discard_open  (framed.discard_open),
  .error_code    (framed.error_code)
);
